>>> src/mae_pkg.sv
`default_nettype none
package mae_pkg;
   localparam int MaxDimDefault = 8;
   localparam int DataWidthDefault = 32;
   localparam int FracBitsDefault = 16;

   localparam logic [3:0] MODE_MUL = 4'd0;
   localparam logic [3:0] MODE_TRN = 4'd1;
   localparam logic [3:0] MODE_EADD = 4'd2;
   localparam logic [3:0] MODE_ESUB = 4'd3;
   localparam logic [3:0] MODE_EMUL = 4'd4;
   localparam logic [3:0] MODE_EDIV = 4'd5;
   localparam logic [3:0] MODE_SADD = 4'd6;
   localparam logic [3:0] MODE_SSUB = 4'd7;
   localparam logic [3:0] MODE_SMUL = 4'd8;
   localparam logic [3:0] MODE_SDIV = 4'd9;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_AROWS = 3'd1;
   localparam logic [2:0] REG_ACOLS = 3'd2;
   localparam logic [2:0] REG_BCOLS = 3'd3;
   localparam logic [2:0] REG_SCALAR = 3'd4;

   typedef struct packed {
      logic start;
      logic sign;
   } div_ctl_type;
endpackage
`default_nettype wire

>>> src/matrix_arith_engine_unit.sv
`default_nettype none
// Fixed-point matrix engine.
// req_ channel: one matrix element per beat, A row-major, then B row-major
// when the mode uses it (multiply, elementwise). Loading takes one beat a
// cycle and gives no results until the beat that completes the load.
// After that beat the input stalls while the full result matrix leaves on
// the rsp_ channel, row-major, with rsp_last_element on the final beat and
// rsp_divide_by_zero on elements that divided by zero.
// Per result element: add, subtract, transpose and divide by zero go
// through memory read, compute and output register; elementwise and scalar
// multiply also go through the multiply; matrix multiply does address,
// read, multiply, accumulate for each term of the dot product on one shared
// multiplier fed from the A and B memories, then scale and output; division
// waits in the bit-serial divider. A stalled receiver holds the result in the
// output register and the sequencer waits; nothing is lost.
// csr_ writes (while idle) set mode, dimensions and scalar, and restart the
// load. Reset clears the load count, registers to mode 0, 8x8x8, scalar 0.
// Operand memories are not cleared; only entries written by a load are read.
module matrix_arith_engine_unit #(
   parameter int MAX_DIM = mae_pkg::MaxDimDefault,
   parameter int DATA_WIDTH = mae_pkg::DataWidthDefault,
   parameter int FRAC_BITS = mae_pkg::FracBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_element_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result_value,
   output logic             rsp_last_element,
   output logic             rsp_divide_by_zero,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import mae_pkg::*;
   localparam int DEPTH = 64;
   localparam int AW = 6;
   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW;
   localparam int ACCW = PW + 4;
   localparam int NW = DW + FRAC_BITS;

   localparam logic [3:0] ST_LOAD = 4'd0;
   localparam logic [3:0] ST_RD = 4'd1;
   localparam logic [3:0] ST_EX = 4'd2;
   localparam logic [3:0] ST_MAC = 4'd3;
   localparam logic [3:0] ST_MACW = 4'd4;
   localparam logic [3:0] ST_DIVW = 4'd5;
   localparam logic [3:0] ST_OUT = 4'd6;
   localparam logic [3:0] ST_MULW = 4'd7;
   localparam logic [3:0] ST_ACCF = 4'd8;

   logic signed [DW-1:0] mem_a [DEPTH];
   logic signed [DW-1:0] mem_b [DEPTH];
   logic signed [DW-1:0] rda_ff, rdb_ff;

   logic [3:0] mode_ff, arows_ff, acols_ff, bcols_ff;
   logic [31:0] scal_ff;
   logic [7:0] cnt_ff, cnt_in;
   logic [3:0] st_ff, st_in;
   logic [3:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [DW-1:0] res_ff, res_in;
   logic last_ff, last_in, dz_ff, dz_in;
   logic neg_ff, neg_in;

   function automatic logic [3:0] dimf(input logic [3:0] v);
      if (v == 4'd0) return 4'd1;
      if (v > 4'(MAX_DIM)) return 4'(MAX_DIM);
      return v;
   endfunction

   function automatic logic signed [DW-1:0] satf(input logic signed [ACCW-1:0] v);
      logic signed [ACCW-1:0] mx, mn;
      mx = ACCW'({1'b0, {(DW-1){1'b1}}});
      mn = ~mx;
      if (v > mx) return mx[DW-1:0];
      if (v < mn) return mn[DW-1:0];
      return v[DW-1:0];
   endfunction

   logic [3:0] mode, r, c, bc, orows, ocols;
   logic [7:0] na, total;
   logic sdiv, sel_scal;
   always_comb begin
      mode = (mode_ff > MODE_SDIV) ? MODE_MUL : mode_ff;
      r = dimf(arows_ff);
      c = dimf(acols_ff);
      bc = dimf(bcols_ff);
      na = 8'(r * c);
      case (mode)
         MODE_MUL: total = na + 8'(c * bc);
         MODE_EADD, MODE_ESUB, MODE_EMUL, MODE_EDIV: total = na + na;
         default: total = na;
      endcase
      orows = (mode == MODE_TRN) ? c : r;
      ocols = (mode == MODE_MUL) ? bc : (mode == MODE_TRN) ? r : c;
      sdiv = (mode == MODE_EDIV) || (mode == MODE_SDIV);
      sel_scal = (mode == MODE_SADD) || (mode == MODE_SSUB) ||
                 (mode == MODE_SMUL) || (mode == MODE_SDIV);
   end

   // addresses
   logic [AW-1:0] wa, ra_a, ra_b;
   logic [7:0] wb;
   always_comb begin
      wa = cnt_ff[AW-1:0];
      wb = cnt_ff - na;
      if (mode == MODE_MUL) begin
         ra_a = AW'(i_ff * c + k_ff);
         ra_b = AW'(k_ff * bc + j_ff);
      end else if (mode == MODE_TRN) begin
         ra_a = AW'(j_ff * c + i_ff);
         ra_b = ra_a;
      end else begin
         ra_a = AW'(i_ff * c + j_ff);
         ra_b = ra_a;
      end
   end

   logic req_fire;
   assign req_ready = (st_ff == ST_LOAD);
   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (cnt_ff < na) mem_a[wa] <= req_element_value[DW-1:0];
         else mem_b[wb[AW-1:0]] <= req_element_value[DW-1:0];
      end
      rda_ff <= mem_a[ra_a];
      rdb_ff <= mem_b[ra_b];
   end

   logic signed [DW-1:0] opb;
   assign opb = sel_scal ? scal_ff[DW-1:0] : rdb_ff;

   // divider
   logic div_start, div_done;
   logic [NW-1:0] div_num, div_q;
   logic [DW-1:0] div_den;
   logic [DW-1:0] amag;
   assign amag = rda_ff[DW-1] ? DW'(-rda_ff) : rda_ff;
   assign div_num = NW'(amag) << FRAC_BITS;
   assign div_den = opb[DW-1] ? DW'(-opb) : opb;

   mae_div #(.NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
   );

   logic out_free;
   assign out_free = !rsp_valid || rsp_ready;
   logic rv_ff, rv_in;

   logic signed [ACCW-1:0] ext_a, ext_b, qv, mx;
   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      last_in = last_ff;
      dz_in = dz_ff;
      neg_in = neg_ff;
      rv_in = rv_ff && !rsp_ready;
      div_start = 1'b0;
      ext_a = ACCW'(rda_ff);
      ext_b = ACCW'(opb);
      mx = ACCW'({1'b0, {(DW-1){1'b1}}});
      qv = '0;
      case (st_ff)
         ST_LOAD: begin
            if (req_fire) begin
               cnt_in = cnt_ff + 8'd1;
               if (cnt_ff + 8'd1 >= total) begin
                  cnt_in = '0;
                  i_in = '0; j_in = '0; k_in = '0;
                  acc_in = '0;
                  st_in = ST_RD;
               end
            end
         end
         ST_RD: st_in = (mode == MODE_MUL) ? ST_MAC : ST_EX;
         ST_MAC: st_in = ST_MULW; // operands read; multiply next
         ST_MULW: st_in = ST_MACW;
         ST_MACW: begin
            acc_in = acc_ff + ACCW'(prod_ff);
            if (k_ff + 4'd1 == c) begin
               st_in = ST_ACCF;
            end else begin
               k_in = k_ff + 4'd1;
               st_in = ST_RD;
            end
         end
         ST_ACCF: begin
            res_in = satf(acc_ff >>> FRAC_BITS);
            dz_in = 1'b0;
            st_in = ST_OUT;
         end
         ST_EX: begin
            dz_in = 1'b0;
            case (mode)
               MODE_TRN: begin
                  res_in = rda_ff;
                  st_in = ST_OUT;
               end
               MODE_EADD, MODE_SADD: begin
                  res_in = satf(ext_a + ext_b);
                  st_in = ST_OUT;
               end
               MODE_ESUB, MODE_SSUB: begin
                  res_in = satf(ext_a - ext_b);
                  st_in = ST_OUT;
               end
               MODE_EMUL, MODE_SMUL: st_in = ST_MULW;
               default: begin
                  if (opb == '0) begin
                     dz_in = 1'b1;
                     res_in = rda_ff[DW-1] ? ~mx[DW-1:0] : mx[DW-1:0];
                     st_in = ST_OUT;
                  end else begin
                     neg_in = rda_ff[DW-1] ^ opb[DW-1];
                     div_start = 1'b1;
                     st_in = ST_DIVW;
                  end
               end
            endcase
            if ((mode == MODE_EMUL) || (mode == MODE_SMUL)) st_in = ST_MAC;
         end
         ST_DIVW: begin
            if (div_done) begin
               if (div_q > NW'(mx) + NW'(1)) qv = mx + ACCW'(1);
               else qv = ACCW'(div_q);
               res_in = satf(neg_ff ? -qv : qv);
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rv_in = 1'b1;
               last_in = (i_ff + 4'd1 == orows) && (j_ff + 4'd1 == ocols);
               k_in = '0;
               acc_in = '0;
               st_in = ST_RD;
               if (j_ff + 4'd1 == ocols) begin
                  j_in = '0;
                  i_in = i_ff + 4'd1;
                  if (i_ff + 4'd1 == orows) st_in = ST_LOAD;
               end else begin
                  j_in = j_ff + 4'd1;
               end
            end
         end
         default: st_in = ST_LOAD;
      endcase
      // elementwise/scalar multiply path: ST_MAC->ST_MULW->finish below
      if (st_ff == ST_MACW && ((mode == MODE_EMUL) || (mode == MODE_SMUL))) begin
         res_in = satf(ACCW'(prod_ff) >>> FRAC_BITS);
         acc_in = acc_ff;
         k_in = k_ff;
         st_in = ST_OUT;
      end
      // any register write restarts the load
      if (csr_write && (csr_index inside {[REG_MODE:REG_SCALAR]})) cnt_in = '0;
   end

   logic out_res_take;
   assign out_res_take = (st_ff == ST_OUT) && out_free;

   always_ff @(posedge clock) begin
      prod_ff <= PW'(rda_ff) * PW'(opb);
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      neg_ff <= neg_in;
      if (out_res_take) begin
         rsp_result_value <= 32'(res_ff);
         rsp_last_element <= last_in;
         rsp_divide_by_zero <= dz_ff;
      end
      last_ff <= last_in;
      dz_ff <= dz_in;
      if (reset) begin
         st_ff <= ST_LOAD;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         mode_ff <= MODE_MUL;
         arows_ff <= 4'd8;
         acols_ff <= 4'd8;
         bcols_ff <= 4'd8;
         scal_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
         if (csr_write) begin
            case (csr_index)
               REG_MODE: mode_ff <= csr_data[3:0];
               REG_AROWS: arows_ff <= csr_data[3:0];
               REG_ACOLS: acols_ff <= csr_data[3:0];
               REG_BCOLS: bcols_ff <= csr_data[3:0];
               REG_SCALAR: scal_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rv_ff;
endmodule
`default_nettype wire

>>> src/mae_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, magnitudes only.
module mae_div #(
   parameter int NW = 48,
   parameter int DW = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quot
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0] r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DW:0] sh;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[NW-2:0], 1'b0};
         if (sh >= {1'b0, den}) begin
            r_in = sh - {1'b0, den};
            q_in[0] = 1'b1;
         end else begin
            r_in = sh;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

>>> test/tb_matrix_arith_engine_unit.sv
module tb_matrix_arith_engine_unit;
   import mae_pkg::*;

   // Index above the register file; the block must ignore it.
   localparam logic [2:0] REG_UNUSED = 3'd5;
   localparam int SETTLE_CYCLES = 150;   // longer than one divide element
   localparam int HOLD_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int ITEM_TARGET = 300;

   typedef struct {
      logic [31:0] value;
      logic last;
      logic dz;
   } result_beat_type;

   typedef struct {
      logic is_csr;
      logic [2:0] idx;
      logic [31:0] data;
      logic pinned;
      logic [31:0] want;
      logic want_dz;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_element_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_result_value;
   logic rsp_last_element;
   logic rsp_divide_by_zero;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   matrix_arith_engine_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_element_value(req_element_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value),
      .rsp_last_element(rsp_last_element),
      .rsp_divide_by_zero(rsp_divide_by_zero),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Engine mirror: registers, operand stores, load counter
   // ---------------------------------------------------------------
   logic [3:0] eng_mode = MODE_MUL;
   logic [3:0] eng_rows = 4'd8;
   logic [3:0] eng_cols = 4'd8;
   logic [3:0] eng_bcols = 4'd8;
   logic [31:0] eng_scalar = '0;
   logic signed [31:0] store_a [64];
   logic signed [31:0] store_b [64];
   logic [7:0] loaded = '0;

   result_beat_type pending_results[$];

   int mismatch_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int loads_done = 0;
   longint cycle_count = 0;

   // Directed rows pin the single result of the next accepted beat.
   logic pin_active = 1'b0;
   result_beat_type pin_beat;

   logic hold_request = 1'b0;

   function automatic int eff_dim(input logic [3:0] v);
      if (v == 0) return 1;
      if (v > 8) return 8;
      return v;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [79:0] v);
      if (v > 80'sd2147483647) return 32'h7fffffff;
      if (v < -80'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic logic [31:0] q_product(input longint a, input longint b);
      longint p;
      p = a * b;
      return sat32(p >>> 16);
   endfunction

   function automatic logic [31:0] q_quotient(input longint a, input longint b,
                                              output logic dz);
      longint na, nb, q;
      dz = 1'b0;
      if (b == 0) begin
         dz = 1'b1;
         return (a >= 0) ? 32'h7fffffff : 32'h80000000;
      end
      na = (a < 0 ? -a : a) <<< 16;
      nb = b < 0 ? -b : b;
      q = na / nb;
      if ((a < 0) != (b < 0)) q = -q;
      return sat32(q);
   endfunction

   // Stores one element and, when the load completes, queues the result matrix.
   task automatic absorb_element(input logic [31:0] v);
      logic [3:0] m;
      int r, c, bc, na, nb, total, orows, ocols, idx;
      longint a, b, s;
      logic signed [79:0] acc;
      result_beat_type beat;
      m = (eng_mode > MODE_SDIV) ? MODE_MUL : eng_mode;
      r = eff_dim(eng_rows);
      c = eff_dim(eng_cols);
      bc = eff_dim(eng_bcols);
      na = r * c;
      nb = (m == MODE_MUL) ? c * bc : (m >= MODE_EADD && m <= MODE_EDIV) ? na : 0;
      total = na + nb;
      s = $signed(eng_scalar);
      if (loaded < na) store_a[loaded & 63] = v;
      else store_b[(loaded - na) & 63] = v;
      loaded = loaded + 8'd1;
      if (loaded >= total) begin
         loaded = '0;
         loads_done++;
         orows = (m == MODE_TRN) ? c : r;
         ocols = (m == MODE_MUL) ? bc : (m == MODE_TRN) ? r : c;
         for (int i = 0; i < orows; i++) begin
            for (int j = 0; j < ocols; j++) begin
               idx = (i * c + j) & 63;
               a = store_a[idx];
               b = store_b[idx];
               beat.dz = 1'b0;
               beat.last = (i + 1 == orows) && (j + 1 == ocols);
               case (m)
                  MODE_MUL: begin
                     acc = '0;
                     for (int k = 0; k < c; k++)
                        acc += longint'(store_a[(i * c + k) & 63]) *
                               longint'(store_b[(k * bc + j) & 63]);
                     beat.value = sat32(acc >>> 16);
                  end
                  MODE_TRN: beat.value = store_a[(j * c + i) & 63];
                  MODE_EADD: beat.value = sat32(a + b);
                  MODE_ESUB: beat.value = sat32(a - b);
                  MODE_EMUL: beat.value = q_product(a, b);
                  MODE_EDIV: beat.value = q_quotient(a, b, beat.dz);
                  MODE_SADD: beat.value = sat32(a + s);
                  MODE_SSUB: beat.value = sat32(a - s);
                  MODE_SMUL: beat.value = q_product(a, s);
                  default: beat.value = q_quotient(a, s, beat.dz);
               endcase
               pending_results.push_back(beat);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Monitors: sample pre-edge values at each rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && csr_write) begin
         case (csr_index)
            REG_MODE: begin eng_mode = csr_data[3:0]; loaded = '0; end
            REG_AROWS: begin eng_rows = csr_data[3:0]; loaded = '0; end
            REG_ACOLS: begin eng_cols = csr_data[3:0]; loaded = '0; end
            REG_BCOLS: begin eng_bcols = csr_data[3:0]; loaded = '0; end
            REG_SCALAR: begin eng_scalar = csr_data; loaded = '0; end
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         items_sent++;
         absorb_element(req_element_value);
         // a pinned row must complete a 1x1 load; its typed value replaces the mirror's
         if (pin_active) begin
            if (pending_results.size() == 0) begin
               $display("%0t: pinned beat produced no result", $time);
               mismatch_count++;
            end else begin
               pending_results[pending_results.size() - 1] = pin_beat;
            end
            pin_active = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      result_beat_type exp_beat;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, got %h", $time, rsp_result_value);
            mismatch_count++;
         end else begin
            exp_beat = pending_results.pop_front();
            if (rsp_result_value !== exp_beat.value) begin
               $display("%0t: result_value expected %h got %h", $time,
                        exp_beat.value, rsp_result_value);
               mismatch_count++;
            end
            if (rsp_last_element !== exp_beat.last) begin
               $display("%0t: last_element expected %b got %b", $time,
                        exp_beat.last, rsp_last_element);
               mismatch_count++;
            end
            if (rsp_divide_by_zero !== exp_beat.dz) begin
               $display("%0t: divide_by_zero expected %b got %b", $time,
                        exp_beat.dz, rsp_divide_by_zero);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      int stall_left, hold_left, pick;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0) stall_left = $urandom_range(10, 40);
            else if (pick < 6) stall_left = $urandom_range(1, 3);
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   // ---------------------------------------------------------------
   // Sender helpers; all entered at a rising edge
   // ---------------------------------------------------------------
   task automatic put_elem(input logic [31:0] v);
      int pick, gap;
      req_valid <= 1'b1;
      req_element_value <= v;
      do @(posedge clock); while (!(req_valid && req_ready));
      pick = $urandom_range(0, 9);
      gap = (pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every expected beat, then let the block settle.
   // The first edge lets the monitor take in a beat accepted at entry.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [2:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value;
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3, 4, 5: return {{12{1'b0}}, 4'($urandom_range(0, 7)), 16'($urandom)} *
                         ($urandom_range(0, 1) ? 32'd1 : 32'hffffffff);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [3:0] pick_dim;
      case ($urandom_range(0, 9))
         0: return 4'd0;
         1: return 4'($urandom_range(9, 15));
         2: return 4'd8;
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic int load_size(input logic [3:0] m, input logic [3:0] r,
                                    input logic [3:0] c, input logic [3:0] bc);
      logic [3:0] mm;
      mm = (m > MODE_SDIV) ? MODE_MUL : m;
      if (mm == MODE_MUL) return eff_dim(r) * eff_dim(c) + eff_dim(c) * eff_dim(bc);
      if (mm >= MODE_EADD && mm <= MODE_EDIV) return 2 * eff_dim(r) * eff_dim(c);
      return eff_dim(r) * eff_dim(c);
   endfunction

   // Directed beats: 1x1 loads make each completing beat yield one result.
   stim_row_type directed_rows[] = '{
      '{1'b1, REG_MODE,   {28'd0, MODE_SDIV}, 1'b0, 32'h0, 1'b0},
      '{1'b1, REG_AROWS,  32'd1,         1'b0, 32'h0, 1'b0},
      '{1'b1, REG_ACOLS,  32'd1,         1'b0, 32'h0, 1'b0},
      '{1'b1, REG_BCOLS,  32'd1,         1'b0, 32'h0, 1'b0},
      '{1'b1, REG_SCALAR, 32'h0,         1'b0, 32'h0, 1'b0},
      // divide by zero saturates by sign of the dividend
      '{1'b0, REG_MODE,   32'h00050000,  1'b1, 32'h7fffffff, 1'b1},
      '{1'b0, REG_MODE,   32'hfffb0000,  1'b1, 32'h80000000, 1'b1},
      '{1'b0, REG_MODE,   32'h0,         1'b1, 32'h7fffffff, 1'b1},
      '{1'b1, REG_MODE,   {28'd0, MODE_TRN},  1'b0, 32'h0, 1'b0},
      '{1'b0, REG_MODE,   32'h80000000,  1'b1, 32'h80000000, 1'b0},
      '{1'b0, REG_MODE,   32'h7fffffff,  1'b1, 32'h7fffffff, 1'b0},
      // scalar add/sub overflow
      '{1'b1, REG_MODE,   {28'd0, MODE_SADD}, 1'b0, 32'h0, 1'b0},
      '{1'b1, REG_SCALAR, 32'h7fffffff,  1'b0, 32'h0, 1'b0},
      '{1'b0, REG_MODE,   32'h1,         1'b1, 32'h7fffffff, 1'b0},
      '{1'b1, REG_MODE,   {28'd0, MODE_SSUB}, 1'b0, 32'h0, 1'b0},
      '{1'b1, REG_SCALAR, 32'h80000000,  1'b0, 32'h0, 1'b0},
      '{1'b0, REG_MODE,   32'h1,         1'b1, 32'h7fffffff, 1'b0},
      // multiply by 1.0
      '{1'b1, REG_MODE,   {28'd0, MODE_SMUL}, 1'b0, 32'h0, 1'b0},
      '{1'b1, REG_SCALAR, 32'h00010000,  1'b0, 32'h0, 1'b0},
      '{1'b0, REG_MODE,   32'h12345678,  1'b1, 32'h12345678, 1'b0},
      // unknown mode acts as multiply; zero dimensions act as one
      '{1'b1, REG_MODE,   32'd12,        1'b0, 32'h0, 1'b0},
      '{1'b1, REG_AROWS,  32'd0,         1'b0, 32'h0, 1'b0},
      '{1'b1, REG_ACOLS,  32'd0,         1'b0, 32'h0, 1'b0},
      '{1'b1, REG_BCOLS,  32'd0,         1'b0, 32'h0, 1'b0},
      '{1'b1, REG_UNUSED, 32'hffffffff,  1'b0, 32'h0, 1'b0},
      '{1'b0, REG_MODE,   32'h00020000,  1'b0, 32'h0, 1'b0},
      '{1'b0, REG_MODE,   32'h00030000,  1'b1, 32'h00060000, 1'b0},
      // half a load, then a register write restarts it
      '{1'b0, REG_MODE,   32'h11111111,  1'b0, 32'h0, 1'b0},
      '{1'b1, REG_MODE,   {28'd0, MODE_EADD}, 1'b0, 32'h0, 1'b0},
      '{1'b0, REG_MODE,   32'h00010000,  1'b0, 32'h0, 1'b0},
      '{1'b0, REG_MODE,   32'h00020000,  1'b1, 32'h00030000, 1'b0}
   };

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      logic [3:0] m, r, c, bc;
      logic [31:0] sc;
      int phase, loads, n, prev_csr;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_csr = 0;
      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_csr) begin
            if (!prev_csr) drain;
            csr_put(directed_rows[k].idx, directed_rows[k].data);
            prev_csr = 1;
         end else begin
            csr_write <= 1'b0;
            if (directed_rows[k].pinned) begin
               // one idle edge so the previous beat is fully taken in first
               req_valid <= 1'b0;
               @(posedge clock);
               pin_beat = '{directed_rows[k].want, 1'b1, directed_rows[k].want_dz};
               pin_active = 1'b1;
            end
            put_elem(directed_rows[k].data);
            prev_csr = 0;
         end
      end
      drain;

      // Random phases: fresh settings, then one or more full loads.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: begin m = MODE_MUL; r = 4'd8; c = 4'd8; bc = 4'd8; end
            1: begin m = MODE_EDIV; r = 4'd4; c = 4'd4; bc = pick_dim(); end
            2: begin
               m = 4'($urandom_range(0, 15));
               r = 4'd2; c = 4'd2; bc = 4'd2;
            end
            default: begin
               m = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
               r = pick_dim();
               c = pick_dim();
               bc = pick_dim();
               // keep most loads small so the long modes stay cheap
               if (phase > 3 && r > 4 && c > 4) c = 4'($urandom_range(1, 3));
            end
         endcase
         sc = ($urandom_range(0, 5) == 0) ? 32'h0 : pick_value();
         csr_put(REG_MODE, {28'd0, m});
         csr_put(REG_AROWS, {28'd0, r});
         csr_put(REG_ACOLS, {28'd0, c});
         csr_put(REG_BCOLS, {28'd0, bc});
         csr_put(REG_SCALAR, sc);
         csr_write <= 1'b0;

         n = load_size(m, r, c, bc);
         loads = (phase == 2) ? 6 : (phase < 2) ? 1 : $urandom_range(1, 3);
         // long receiver hold-off while loads keep coming
         if (phase == 2) hold_request = 1'b1;
         for (int l = 0; l < loads && items_sent < ITEM_TARGET; l++) begin
            for (int e = 0; e < n; e++) put_elem(pick_value());
            // once, wait for every result before the next load
            if (phase == 3) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_results.size() != 0) @(posedge clock);
            end
         end
         // sometimes leave a broken load for the next write to discard
         if ($urandom_range(0, 7) == 0 && n > 1) begin
            repeat ($urandom_range(1, n - 1)) put_elem(pick_value());
         end
         drain;
         phase++;
      end

      $display("Sent %0d element beats over %0d setting phases, %0d loads completed,",
               items_sent, phase, loads_done);
      $display("checked %0d result beats across all modes and dimension limits.",
               results_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/mae_pkg.sv
src/mae_div.sv
src/matrix_arith_engine_unit.sv
test/tb_matrix_arith_engine_unit.sv
